>>> rtl/mdt_pkg.sv
// ----------------------------------------------------------------------------
// Maximum drawdown tracker package
// Shared widths, payload types and the controller-to-datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package mdt_pkg;

  // Width of one equity sample and of the Q0.N drawdown fraction.
  localparam int VALUE_BITS = 40;
  localparam int FRAC_BITS  = 16;
  localparam int CNT_BITS   = $clog2(FRAC_BITS);

  // One input beat.
  typedef struct packed {
    logic [VALUE_BITS-1:0] equity_value;
    logic                  first_sample;
    logic                  last_sample;
  } mdt_in_t;

  // One result beat.
  typedef struct packed {
    logic [FRAC_BITS-1:0] current_drawdown;
    logic [FRAC_BITS-1:0] max_drawdown;
    logic                 curve_done;
  } mdt_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // Capture an accepted sample and update the peak.
    logic prep;    // Form the difference and the special-case flags.
    logic step;    // One restoring-division step.
    logic finish;  // Update the worst drawdown and load the result register.
  } mdt_cmd_t;

endpackage

`default_nettype wire

>>> rtl/mdt_ctrl.sv
// ----------------------------------------------------------------------------
// Maximum drawdown tracker controller
// Sequences load, setup, division steps and result hand-off for one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module mdt_ctrl
  import mdt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output mdt_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [CNT_BITS-1:0] count;
  logic                fin_go;

  // The result register may be reloaded once it is empty or being taken.
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE);

  assign cmd.load   = in_valid && in_ready;
  assign cmd.prep   = (state == S_PREP);
  assign cmd.step   = (state == S_DIV);
  assign cmd.finish = fin_go;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_PREP;
      end
      S_PREP: state_next = S_DIV;
      S_DIV: begin
        if (count == CNT_BITS'(FRAC_BITS - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        if (fin_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, step counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_PREP) begin
        count <= '0;
      end else if (state == S_DIV) begin
        count <= count + CNT_BITS'(1);
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/mdt_datapath.sv
// ----------------------------------------------------------------------------
// Maximum drawdown tracker datapath
// Peak and worst-drawdown state, a radix-2 restoring divider and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdt_datapath
  import mdt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mdt_cmd_t cmd,
  input  wire mdt_in_t  in_data,
  output mdt_out_t      out_data
);

  logic [VALUE_BITS-1:0] peak;
  logic [FRAC_BITS-1:0]  worst;
  logic [VALUE_BITS-1:0] value;
  logic                  last;
  logic [VALUE_BITS-1:0] rem;
  logic [FRAC_BITS-1:0]  quo;
  logic                  peak_zero;
  logic                  full_loss;

  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   trial;
  logic                  fits;
  logic [FRAC_BITS-1:0]  dd;
  logic [FRAC_BITS-1:0]  worst_next;

  // One restoring step: shift the remainder and subtract the peak if it fits.
  assign shifted = {rem, 1'b0};
  assign trial   = shifted - {1'b0, peak};
  assign fits    = (shifted >= {1'b0, peak});

  // Special cases: a zero peak gives zero, a total loss saturates.
  always_comb begin
    if (peak_zero) begin
      dd = '0;
    end else if (full_loss) begin
      dd = '1;
    end else begin
      dd = quo;
    end
    worst_next = (dd > worst) ? dd : worst;
  end

  // Curve state, which reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      peak  <= '0;
      worst <= '0;
    end else begin
      if (cmd.load) begin
        if (in_data.first_sample) begin
          peak  <= in_data.equity_value;
          worst <= '0;
        end else if (in_data.equity_value > peak) begin
          peak <= in_data.equity_value;
        end
      end else if (cmd.finish) begin
        worst <= worst_next;
      end
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= in_data.equity_value;
      last  <= in_data.last_sample;
    end
    if (cmd.prep) begin
      rem       <= peak - value;
      quo       <= '0;
      peak_zero <= (peak == '0);
      full_loss <= (value == '0);
    end else if (cmd.step) begin
      rem <= fits ? trial[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
      quo <= {quo[FRAC_BITS-2:0], fits};
    end
    if (cmd.finish) begin
      out_data.current_drawdown <= dd;
      out_data.max_drawdown     <= worst_next;
      out_data.curve_done       <= last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/max_drawdown_tracker_top.sv
// ----------------------------------------------------------------------------
// Maximum drawdown tracker
// Running peak and maximum fractional drawdown of an equity curve.
// ----------------------------------------------------------------------------
// Each beat carries a 40-bit unsigned equity sample with marks for the first
// and last sample of a curve. For every sample the block returns the drawdown
// floor((peak - value) * 2^16 / peak) as an unsigned Q0.16 fraction,
// saturated to 65535 on a total loss and 0 when the peak is 0, together with
// the largest drawdown of the curve so far and an echo of the last mark. The
// peak is updated at the accepting edge; the block then forms the difference,
// runs 16 steps of the radix-2 restoring divider, and updates the maximum and
// loads the output register, which makes the result valid. The block is
// ready for the next sample in the cycle after that, and takes no new sample
// before the previous one is finished; a result still unread in the output
// register holds off only the final update of the following sample. The next
// sample is accepted while a result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module max_drawdown_tracker_top
  import mdt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire mdt_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output mdt_out_t     out_data
);

  mdt_cmd_t cmd;

  // Sequencing.
  mdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  mdt_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Maximum drawdown tracker testbench
// Drives equity beats through max_drawdown_tracker_top under several idle
// patterns and checks every result beat against an in-bench predictor.
// ----------------------------------------------------------------------------
// Directed tests cover samples before any first mark, total loss, a zero
// peak, the value extremes and exact fractions. Random curves follow, mostly
// well formed with a first and a last mark, some with scrambled marks, while
// the sender and the receiver idle at different rates. Each accepted sample
// updates a private copy of the peak and worst drawdown, and the expected
// result beat is queued for the checker.
// ----------------------------------------------------------------------------

module tb_top;
  import mdt_pkg::*;

  localparam int                    WATCHDOG_CYCLES = 5000;
  localparam int                    DRAIN_CYCLES    = 40;
  localparam int                    MAX_PRINTED     = 100;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX       = '1;
  localparam logic [VALUE_BITS-1:0] VALUE_HALF      = VALUE_MAX / 2 + 1;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  mdt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mdt_out_t out_data;

  // Predictor state for the curve in flight.
  logic [VALUE_BITS-1:0] curve_peak  = '0;
  logic [FRAC_BITS-1:0]  curve_worst = '0;
  mdt_out_t              expected_results[$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  max_drawdown_tracker_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Drawdown of a sample below the peak as a saturated Q0.16 fraction.
  function automatic logic [FRAC_BITS-1:0] drawdown_q16(
    input logic [VALUE_BITS-1:0] peak,
    input logic [VALUE_BITS-1:0] value
  );
    logic [VALUE_BITS-1:0]           diff;
    logic [VALUE_BITS+FRAC_BITS-1:0] scaled;
    logic [VALUE_BITS+FRAC_BITS-1:0] quotient;
    if (peak == '0) begin
      return '0;
    end
    diff = peak - value;
    if (diff >= peak) begin
      return '1;
    end
    scaled   = {diff, {FRAC_BITS{1'b0}}};
    quotient = scaled / peak;
    return quotient[FRAC_BITS-1:0];
  endfunction

  // Update the curve state with an accepted sample and queue its result.
  task automatic track_sample(input mdt_in_t item);
    mdt_out_t             result;
    logic [FRAC_BITS-1:0] drawdown;
    if (item.first_sample) begin
      curve_peak  = item.equity_value;
      curve_worst = '0;
    end else if (item.equity_value > curve_peak) begin
      curve_peak = item.equity_value;
    end
    drawdown = drawdown_q16(curve_peak, item.equity_value);
    if (drawdown > curve_worst) begin
      curve_worst = drawdown;
    end
    result.current_drawdown = drawdown;
    result.max_drawdown     = curve_worst;
    result.curve_done       = item.last_sample;
    expected_results = {expected_results, result};
  endtask

  // Send one sample beat, idling first if the current pattern says so.
  task automatic send_sample(
    input logic [VALUE_BITS-1:0] value,
    input logic                  first,
    input logic                  last
  );
    mdt_in_t item;
    item.equity_value = value;
    item.first_sample = first;
    item.last_sample  = last;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    track_sample(item);
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) begin
      $display("%0t ns: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Result side: random back-pressure and a field-by-field check of each beat.
  always @(posedge clk) begin
    mdt_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_data.current_drawdown !== want.current_drawdown) begin
            report_mismatch($sformatf("current_drawdown got %0d want %0d",
                                      out_data.current_drawdown, want.current_drawdown));
          end
          if (out_data.max_drawdown !== want.max_drawdown) begin
            report_mismatch($sformatf("max_drawdown got %0d want %0d",
                                      out_data.max_drawdown, want.max_drawdown));
          end
          if (out_data.curve_done !== want.curve_done) begin
            report_mismatch($sformatf("curve_done got %0b want %0b",
                                      out_data.curve_done, want.curve_done));
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("tb_top: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Next sample of a random equity curve: mostly moves around the last level.
  function automatic logic [VALUE_BITS-1:0] next_level(input logic [VALUE_BITS-1:0] level);
    logic [VALUE_BITS:0]   raised;
    logic [VALUE_BITS-1:0] delta;
    delta = level >> $urandom_range(1, 12);
    if (delta == '0) begin
      delta = VALUE_BITS'($urandom_range(0, 3));
    end
    case ($urandom_range(0, 15))
      0: return '0;
      1: return VALUE_MAX;
      2: return VALUE_BITS'({$urandom(), $urandom()});
      3: return level;
      4: return VALUE_BITS'($urandom_range(0, 255));
      5, 6, 7, 8, 9: return (delta > level) ? '0 : level - delta;
      default: begin
        raised = level + delta;
        return raised[VALUE_BITS] ? VALUE_MAX : raised[VALUE_BITS-1:0];
      end
    endcase
  endfunction

  // Samples before any first mark run on the reset state.
  task automatic test_no_first_mark();
    send_sample('0, 1'b0, 1'b0);
    send_sample(40'd5, 1'b0, 1'b0);
    send_sample(40'd3, 1'b0, 1'b0);
    send_sample('0, 1'b0, 1'b1);
  endtask

  // A sample of zero under a nonzero peak saturates the drawdown.
  task automatic test_full_loss();
    send_sample(VALUE_MAX, 1'b1, 1'b0);
    send_sample('0, 1'b0, 1'b0);
    send_sample(40'd1, 1'b0, 1'b0);
    send_sample(40'd1, 1'b1, 1'b0);
    send_sample('0, 1'b0, 1'b1);
  endtask

  // A curve that sits at zero reports no drawdown.
  task automatic test_zero_peak();
    send_sample('0, 1'b1, 1'b0);
    send_sample('0, 1'b0, 1'b0);
    send_sample(40'd7, 1'b0, 1'b0);
    send_sample('0, 1'b1, 1'b1);
  endtask

  // Largest values, exact fractions and a one-sample curve.
  task automatic test_extremes();
    send_sample(VALUE_MAX, 1'b1, 1'b0);
    send_sample(VALUE_MAX - 1, 1'b0, 1'b0);
    send_sample(VALUE_HALF, 1'b0, 1'b1);
    send_sample(40'd3, 1'b1, 1'b0);
    send_sample(40'd1, 1'b0, 1'b0);
    send_sample(40'd3, 1'b0, 1'b0);
    send_sample(40'd2, 1'b0, 1'b1);
    send_sample(40'hAA_AAAA_AAAA, 1'b1, 1'b1);
    send_sample(40'h55_5555_5555, 1'b0, 1'b0);
  endtask

  // Random curves, mostly well marked; one in ten samples gets random marks.
  task automatic test_random_curves(input int sample_total);
    int                    sent;
    int                    curve_len;
    int                    k;
    logic [VALUE_BITS-1:0] level;
    logic                  first;
    logic                  last;
    sent = 0;
    while (sent < sample_total) begin
      curve_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      level = VALUE_BITS'({$urandom(), $urandom()}) >> $urandom_range(0, VALUE_BITS - 1);
      for (k = 0; k < curve_len; k++) begin
        first = (k == 0);
        last  = (k == curve_len - 1);
        if ($urandom_range(0, 9) == 0) begin
          first = 1'($urandom_range(0, 1));
          last  = 1'($urandom_range(0, 1));
        end
        send_sample(level, first, last);
        sent++;
        level = next_level(level);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_first_mark();
    test_full_loss();
    test_zero_peak();
    test_extremes();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_curves(400);
    send_idle_pct  = 61;
    recv_stall_pct = 0;
    test_random_curves(400);
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    test_random_curves(400);
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    test_random_curves(400);
    in_valid <= 1'b0;

    // Let every outstanding result drain, then allow for stray beats.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mdt_pkg.sv
rtl/mdt_ctrl.sv
rtl/mdt_datapath.sv
rtl/max_drawdown_tracker_top.sv
bench/tb_top.sv
